@@ hdl/rsc_pkg.sv @@
package rsc_pkg;

  localparam int MaxSamplesDef = 1024;
  localparam int SampleBitsDef = 16;
  localparam int ValueBits     = 26;
  localparam int CfgBits       = 17;

  localparam logic [25:0] Vmax    = 26'h3FF_FFFF;
  localparam logic [16:0] One16   = 17'h10000;
  localparam logic [31:0] Ln2Q30  = 32'd744261118;
  localparam logic [31:0] Log2eQ24 = 32'd24204407;

  typedef enum logic [2:0] {
    MODE_MAX   = 3'd0,
    MODE_MIN   = 3'd1,
    MODE_MEAN  = 3'd2,
    MODE_SUM   = 3'd3,
    MODE_ALPHA = 3'd4,
    MODE_BEER  = 3'd5,
    MODE_NONE6 = 3'd6,
    MODE_NONE7 = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_RLOW    = 3'd1,
    REG_RHIGH   = 3'd2,
    REG_OSCALE  = 3'd3,
    REG_EXT     = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FOLD,
    ST_RDIV,
    ST_A_OP,
    ST_A_W,
    ST_A_COL,
    ST_A_ADD,
    ST_FIN,
    ST_MDIV,
    ST_B_X,
    ST_B_Y,
    ST_B_Z,
    ST_B_ZP,
    ST_B_DIV,
    ST_B_END,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

@@ hdl/rsc_div.sv @@
module rsc_div
  import rsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] quo;
  logic [63:0] num;
  logic [32:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], num[63]};
  assign trial   = shifted - {1'b0, den};

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      if (!trial[32]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ hdl/ray_sample_compositor.sv @@
// Result: after the last sample is folded, max, min, sum, alpha and unused modes present the
// result word directly; mean first makes one 64-step shared divider pass and beer-lambert runs
// three multiplies, then seven Horner steps of a multiply and a divide by the Horner index.
// Input: a sample is taken once the previous one is folded; alpha adds opacity multiplies and,
// for a partial ramp, a divide. A held result word stalls input only once the next one is ready.
// Reset: synchronous, active high; restores register defaults and clears the ray state.
module ray_sample_compositor
  import rsc_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [CfgBits-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ValueBits-1:0]   value
);

  localparam int CntBits = $clog2(MAX_SAMPLES + 1);

  // configuration registers
  mode_t       mode;
  logic [15:0] ramp_low;
  logic [15:0] ramp_high;
  logic [16:0] opacity_scale;
  logic [15:0] extinction_coeff;

  // ray state
  logic [25:0]        running_value, running_value_next;
  logic [16:0]        alpha_total, alpha_total_next;
  logic [CntBits-1:0] samples_seen, samples_seen_next;
  logic               opaque_reached, opaque_reached_next;

  // captured word and scratch
  logic [15:0] v, v_next;
  logic        lst, lst_next;
  logic [63:0] acc, acc_next;
  logic [2:0]  k, k_next;
  logic [4:0]  ip, ip_next;
  logic [25:0] res, res_next;
  logic [31:0] hn, hn_next;
  logic        out_load;

  state_t   state, state_next;
  div_req_t dreq;
  div_rsp_t drsp;

  // shared multiplier: 32x32, operands picked by the sequencer
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  assign mprod = ma * mb;

  rsc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Reciprocals of the Horner index, scaled by 2^32; exact for dividends below 2^30.
  // Index one passes the dividend through.
  function automatic logic [31:0] recip_k(input logic [2:0] kk);
    logic [31:0] m;
    unique case (kk)
      3'd2:    m = 32'h8000_0000;
      3'd3:    m = 32'd1431655766;
      3'd4:    m = 32'h4000_0000;
      3'd5:    m = 32'd858993460;
      3'd6:    m = 32'd715827883;
      3'd7:    m = 32'd613566757;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  // ramp operands
  logic [16:0] num_s, den_s, an, ad;
  logic        num_neg, den_neg, ramp_zero;
  logic [16:0] sv16;
  always_comb begin
    sv16    = {1'b0, v};
    num_s   = sv16 - {1'b0, ramp_low};
    den_s   = {1'b0, ramp_high} - {1'b0, ramp_low};
    num_neg = num_s[16];
    den_neg = den_s[16];
    an      = num_neg ? (~num_s + 17'd1) : num_s;
    ad      = den_neg ? (~den_s + 17'd1) : den_s;
    ramp_zero = (den_s == '0) || (num_s == '0) || (num_neg != den_neg);
  end

  logic [15:0] vq;
  always_comb begin
    if (SAMPLE_BITS >= 16) vq = 16'(sample >> (SAMPLE_BITS - 16));
    else                   vq = 16'({{(16 - (SAMPLE_BITS < 16 ? SAMPLE_BITS : 15)){1'b0}},
                                     sample} << (16 - SAMPLE_BITS));
  end

  logic [26:0] sum27;
  logic [25:0] sat_sum;
  logic [16:0] sc;
  always_comb begin
    sum27   = {1'b0, running_value} + {11'd0, v};
    sat_sum = sum27[26] ? Vmax : sum27[25:0];
    sc      = (opacity_scale > One16) ? One16 : opacity_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_MAX;
      ramp_low         <= 16'd0;
      ramp_high        <= 16'hFFFF;
      opacity_scale    <= One16;
      extinction_coeff <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode             <= mode_t'(cfg_data[2:0]);
        REG_RLOW:   ramp_low         <= cfg_data[15:0];
        REG_RHIGH:  ramp_high        <= cfg_data[15:0];
        REG_OSCALE: opacity_scale    <= cfg_data;
        REG_EXT:    extinction_coeff <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_value  <= '0;
      alpha_total    <= '0;
      samples_seen   <= '0;
      opaque_reached <= 1'b0;
    end else begin
      state          <= state_next;
      running_value  <= running_value_next;
      alpha_total    <= alpha_total_next;
      samples_seen   <= samples_seen_next;
      opaque_reached <= opaque_reached_next;
    end
  end

  always_ff @(posedge clk) begin
    v   <= v_next;
    lst <= lst_next;
    acc <= acc_next;
    k   <= k_next;
    ip  <= ip_next;
    res <= res_next;
    hn  <= hn_next;
  end

  // output register: hold the result word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) value <= res;
  end

  logic [17:0] alpha_sum;
  logic [63:0] p_cur;
  logic [31:0] half_n;
  logic [31:0] q_k;

  always_comb begin
    state_next          = state;
    running_value_next  = running_value;
    alpha_total_next    = alpha_total;
    samples_seen_next   = samples_seen;
    opaque_reached_next = opaque_reached;
    v_next   = v;
    lst_next = lst;
    acc_next = acc;
    k_next   = k;
    ip_next  = ip;
    res_next = res;
    hn_next  = hn;
    ma = '0;
    mb = '0;
    dreq = '0;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    alpha_sum = '0;
    p_cur     = '0;
    q_k       = '0;
    half_n    = 32'(samples_seen >> 1);

    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          v_next     = vq;
          lst_next   = last;
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_next = ST_FIN;
        if (samples_seen < CntBits'(MAX_SAMPLES)) begin
          samples_seen_next = samples_seen + 1'b1;
          unique case (mode)
            MODE_MAX: if (samples_seen == '0 || {10'd0, v} > running_value)
              running_value_next = {10'd0, v};
            MODE_MIN: if (samples_seen == '0 || {10'd0, v} < running_value)
              running_value_next = {10'd0, v};
            MODE_MEAN, MODE_SUM, MODE_BEER: running_value_next = sat_sum;
            MODE_ALPHA: begin
              if (!opaque_reached) begin
                if (ramp_zero) begin
                  // zero opacity leaves the running value and alpha unchanged
                  state_next = ST_FIN;
                end else if (an >= ad) begin
                  acc_next   = {47'd0, One16};
                  state_next = ST_A_OP;
                end else begin
                  dreq.start = 1'b1;
                  dreq.num   = {31'd0, an, 16'd0};
                  dreq.den   = {15'd0, ad};
                  state_next = ST_RDIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDIV: begin
        if (drsp.done) begin
          acc_next   = drsp.quo;
          state_next = ST_A_OP;
        end
      end
      ST_A_OP: begin
        ma = acc[31:0];
        mb = {15'd0, sc};
        acc_next   = mprod >> 16;
        state_next = ST_A_W;
      end
      ST_A_W: begin
        ma = {15'd0, One16 - alpha_total};
        mb = acc[31:0];
        acc_next   = mprod >> 16;
        state_next = ST_A_COL;
      end
      ST_A_COL: begin
        ma = acc[31:0];
        mb = {16'd0, v};
        alpha_sum = {1'b0, alpha_total} + 18'(acc[16:0]);
        if ({6'd0, running_value} + 32'(mprod >> 16) > 32'(Vmax))
          running_value_next = Vmax;
        else
          running_value_next = 26'({6'd0, running_value} + 32'(mprod >> 16));
        if (alpha_sum >= {1'b0, One16}) begin
          alpha_total_next    = One16;
          opaque_reached_next = 1'b1;
        end else begin
          alpha_total_next = alpha_sum[16:0];
        end
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!lst) begin
          state_next = ST_IDLE;
        end else begin
          unique case (mode)
            MODE_MAX, MODE_MIN, MODE_SUM, MODE_ALPHA: begin
              res_next   = running_value;
              state_next = ST_OUT;
            end
            MODE_MEAN: begin
              dreq.start = 1'b1;
              dreq.num   = {38'd0, running_value} + {32'd0, half_n};
              dreq.den   = 32'(samples_seen);
              state_next = ST_MDIV;
            end
            MODE_BEER: state_next = ST_B_X;
            default: begin
              res_next   = '0;
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_MDIV: begin
        if (drsp.done) begin
          res_next   = drsp.quo[25:0];
          state_next = ST_OUT;
        end
      end
      ST_B_X: begin
        ma = {16'd0, extinction_coeff};
        mb = {6'd0, running_value};
        acc_next   = mprod >> 8;
        state_next = ST_B_Y;
      end
      ST_B_Y: begin
        // x < 2^34: split into two halves to keep within 32x32
        ma = acc[31:0];
        mb = Log2eQ24;
        acc_next   = (mprod >> 24) + ({30'd0, acc[33:32]} * {32'd0, Log2eQ24} << 8);
        state_next = ST_B_Z;
      end
      ST_B_Z: begin
        if (acc[63:16] >= 48'd17) begin
          res_next   = '0;
          state_next = ST_OUT;
        end else begin
          ip_next    = acc[20:16];
          ma = {16'd0, acc[15:0]};
          mb = Ln2Q30;
          acc_next   = {32'd0, 32'(mprod >> 16)} << 32 | 64'h4000_0000;
          k_next     = 3'd7;
          state_next = ST_B_ZP;
        end
      end
      ST_B_ZP: begin
        // acc[63:32] = z, acc[31:0] = p
        ma = acc[63:32];
        mb = acc[31:0];
        hn_next    = 32'(mprod >> 30);
        state_next = ST_B_DIV;
      end
      ST_B_DIV: begin
        // divide by the Horner index through a reciprocal multiply
        ma = hn;
        mb = recip_k(k);
        q_k      = (k == 3'd1) ? hn : mprod[63:32];
        p_cur    = 64'h4000_0000 - {32'd0, q_k};
        acc_next = {acc[63:32], p_cur[31:0]};
        if (k == 3'd1) state_next = ST_B_END;
        else begin
          k_next     = k - 3'd1;
          state_next = ST_B_ZP;
        end
      end
      ST_B_END: begin
        p_cur      = {32'd0, acc[31:0]} + (64'd1 << (13 + ip));
        res_next   = 26'(p_cur >> (14 + ip));
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // load the result word once the output register is free
        if (!out_valid || !out_stall) begin
          out_load            = 1'b1;
          running_value_next  = '0;
          alpha_total_next    = '0;
          samples_seen_next   = '0;
          opaque_reached_next = 1'b0;
          state_next          = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_alpha_cap: assert property (@(posedge clk) disable iff (rst)
    alpha_total <= One16) else $error("alpha above one");
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    opaque_reached |-> alpha_total == One16) else $error("opaque flag without full alpha");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    samples_seen <= CntBits'(MAX_SAMPLES)) else $error("sample count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value)) else $error("result dropped");

endmodule

@@ test/tb_ray_sample_compositor.sv @@
`timescale 1ns / 1ps
module tb_ray_sample_compositor;
  import rsc_pkg::*;

  localparam int RayCap = 1024;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [2:0]           cfg_index;
  logic [CfgBits-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [15:0]          sample;
  logic                 last;
  logic                 out_valid;
  logic                 out_stall;
  logic [ValueBits-1:0] value;

  ray_sample_compositor u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .value(value)
  );

  // Predictor copy of the register file and the ray state.
  mode_t       cur_mode;
  logic [15:0] cur_rlow, cur_rhigh, cur_ext;
  logic [16:0] cur_oscale;
  logic [25:0] ray_acc;
  logic [16:0] ray_alpha;
  int          ray_count;
  bit          ray_opaque;

  logic [25:0] composite_q[$];
  int          mismatch_count;
  bit          quiet_in;   // turn off sender idling
  bit          quiet_out;  // turn off receiver stalling

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [25:0] got,
                                 input logic [25:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic logic [25:0] sat26(input logic [63:0] s);
    return (s > 64'h3FF_FFFF) ? 26'h3FF_FFFF : s[25:0];
  endfunction

  function automatic logic [16:0] ramp_opacity(input logic [15:0] s);
    longint num, den, an, ad;
    num = longint'(s) - longint'(cur_rlow);
    den = longint'(cur_rhigh) - longint'(cur_rlow);
    if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return 17'd0;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= ad) return 17'h10000;
    return 17'((an << 16) / ad);
  endfunction

  function automatic logic [25:0] attenuation(input logic [25:0] total);
    logic [63:0] x, y, ip, f, z, p;
    x = (64'(cur_ext) * 64'(total)) >> 8;
    y = (x * 64'(Log2eQ24)) >> 24;
    ip = y >> 16;
    f = y & 64'hFFFF;
    z = (f * 64'(Ln2Q30)) >> 16;
    p = 64'd1073741824;
    if (ip >= 17) return 26'd0;
    for (int k = 7; k >= 1; k--)
      p = 64'd1073741824 - ((z * p) >> 30) / k;
    return 26'((p + (64'd1 << (13 + ip))) >> (14 + ip));
  endfunction

  // Fold one word into the ray; push the composite when it ends the ray.
  task automatic fold_sample(input logic [15:0] s, input bit lst);
    logic [63:0] sc, op, w;
    logic [25:0] res;
    if (ray_count < RayCap) begin
      case (cur_mode)
        MODE_MAX: if (ray_count == 0 || 26'(s) > ray_acc) ray_acc = 26'(s);
        MODE_MIN: if (ray_count == 0 || 26'(s) < ray_acc) ray_acc = 26'(s);
        MODE_MEAN, MODE_SUM, MODE_BEER: ray_acc = sat26(64'(ray_acc) + 64'(s));
        MODE_ALPHA: if (!ray_opaque) begin
          sc = cur_oscale > 17'h10000 ? 64'h10000 : 64'(cur_oscale);
          op = (64'(ramp_opacity(s)) * sc) >> 16;
          w = ((64'h10000 - 64'(ray_alpha)) * op) >> 16;
          ray_acc = sat26(64'(ray_acc) + ((w * 64'(s)) >> 16));
          if (64'(ray_alpha) + w >= 64'h10000) begin
            ray_alpha = 17'h10000;
            ray_opaque = 1'b1;
          end else begin
            ray_alpha = 17'(64'(ray_alpha) + w);
          end
        end
        default: ;
      endcase
      ray_count++;
    end
    if (lst) begin
      case (cur_mode)
        MODE_MAX, MODE_MIN, MODE_SUM, MODE_ALPHA: res = ray_acc;
        MODE_MEAN: res = 26'((64'(ray_acc) + ray_count / 2) / ray_count);
        MODE_BEER: res = attenuation(ray_acc);
        default: res = 26'd0;
      endcase
      composite_q.push_back(res);
      ray_acc = '0;
      ray_alpha = '0;
      ray_count = 0;
      ray_opaque = 1'b0;
    end
  endtask

  // Drop valid while idling, hold valid and the word until the block takes it.
  task automatic send_sample(input logic [15:0] s, input bit lst);
    while (!quiet_in && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_sample(s, lst);
  endtask

  task automatic send_ray(input int len, input int lo, input int hi);
    for (int i = 0; i < len; i++)
      send_sample(16'($urandom_range(hi, lo)), i == len - 1);
  endtask

  // Wait for the queue to drain, then let an in-flight word finish.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (composite_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [16:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:   cur_mode = mode_t'(data[2:0]);
      REG_RLOW:   cur_rlow = data[15:0];
      REG_RHIGH:  cur_rhigh = data[15:0];
      REG_OSCALE: cur_oscale = data;
      REG_EXT:    cur_ext = data[15:0];
      default: ;
    endcase
  endtask

  // Check every accepted composite against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (composite_q.size() == 0) begin
        report_mismatch("unexpected composite", value, 26'd0);
      end else begin
        automatic logic [25:0] want = composite_q.pop_front();
        if (value !== want) report_mismatch("value", value, want);
      end
    end
  end

  // Receiver stalls at random unless quieted.
  always @(posedge clk) begin
    if (rst || quiet_out) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 20);
  end

  task automatic test_extremes();
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MODE, 17'(m));
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'hFFFF, 1'b1);
      drain();
    end
  endtask

  task automatic test_alpha_cases();
    write_reg(REG_MODE, MODE_ALPHA);
    write_reg(REG_OSCALE, 17'h1FFFF);   // scale above one acts as one
    send_ray(4, 60000, 65535);           // alpha nears one; opaque, ignoring later words, only after a 65535 word
    drain();
    write_reg(REG_RLOW, 17'd1000);
    write_reg(REG_RHIGH, 17'd1000);     // zero-width ramp
    send_ray(3, 0, 65535);
    drain();
    write_reg(REG_RHIGH, 17'd0);        // reversed ramp
    send_ray(5, 0, 65535);
    drain();
  endtask

  task automatic test_long_ray();
    write_reg(REG_MODE, MODE_SUM);
    quiet_in = 1'b1;
    send_ray(RayCap + 20, 65000, 65535); // runs near full scale, then passes the cap
    quiet_in = 1'b0;
    drain();
  endtask

  task automatic test_mode_switch();
    write_reg(REG_MODE, MODE_MAX);
    send_sample(16'd300, 1'b0);
    drain();
    write_reg(REG_MODE, MODE_SUM);
    send_sample(16'd5, 1'b0);
    drain();
    write_reg(REG_MODE, MODE_MEAN);
    send_sample(16'd9, 1'b1);
    drain();
  endtask

  task automatic test_random();
    for (int r = 0; r < 100; r++) begin
      if (r % 25 == 0) begin
        drain();
        write_reg(REG_MODE, 17'($urandom_range(7)));
        write_reg(REG_RLOW, 17'($urandom_range(65535)));
        write_reg(REG_RHIGH, ($urandom_range(3) == 0) ? 17'hFFFF : 17'($urandom_range(65535)));
        write_reg(REG_OSCALE, 17'($urandom_range(131071)));
        write_reg(REG_EXT, ($urandom_range(1) == 0) ? 17'($urandom_range(1024))
                                                    : 17'($urandom_range(65535)));
      end
      quiet_in  = (r >= 30 && r < 50);
      quiet_out = quiet_in;
      send_ray($urandom_range(8, 1), 0, 65535);
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    last = 1'b0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    mismatch_count = 0;
    cur_mode = MODE_MAX;
    cur_rlow = 16'd0;
    cur_rhigh = 16'hFFFF;
    cur_oscale = 17'h10000;
    cur_ext = 16'd256;
    ray_acc = '0;
    ray_alpha = '0;
    ray_count = 0;
    ray_opaque = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_alpha_cases();
    test_mode_switch();
    test_long_ray();
    test_random();
    drain();
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
